### rtl/core/pwl_pkg.sv
package pwl_pkg;

  // Field widths
  localparam int X_W    = 16;
  localparam int Y_W    = 16;
  localparam int RES_W  = 36;
  localparam int ST_W   = 3;

  // Arithmetic widths: differences of two 16-bit values, their product,
  // and the divisor magnitude (at most 65535)
  localparam int DIFF_W = 17;
  localparam int NUM_W  = 34;
  localparam int DVS_W  = 16;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  // Result status codes
  localparam logic [ST_W-1:0] ST_EXACT    = 3'd0;
  localparam logic [ST_W-1:0] ST_INTERP   = 3'd1;
  localparam logic [ST_W-1:0] ST_APPENDED = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd4;

  // Item modes
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // Bracket start points
  localparam logic signed [X_W-1:0] FLOOR_X_START = 16'sd0;
  localparam logic signed [X_W-1:0] CEIL_X_START  = 16'sd9999;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic mul;
    logic div_init;
    logic div_step;
    logic finish;
  } pwl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic scan_done;
    logic matched;
    logic den_zero;
    logic div_done;
    logic out_free;
  } pwl_stat_t;

endpackage

### rtl/core/piecewise_linear_table_interp.sv
// Channel  Handshake           Fields
// -------  ------------------  -----------------------------
// input    in_valid/in_ready   mode, x_value, y_value
// output   out_valid/out_ready y_result, status
//
// One item at a time. An append passes from accept through the scan
// state to the finish state. For a query the table scan reads one point
// per cycle from the point memory, then the serial divider produces one
// quotient bit per cycle (34 bits). An exact match or a zero divisor
// skips the divider.
// rst clears the point count and all control; no clearing pass is needed.
// A waiting result stalls the next item at its finish until it is taken.
module piecewise_linear_table_interp import pwl_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  logic signed [X_W-1:0]   x_value,
  input  logic signed [Y_W-1:0]   y_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [RES_W-1:0] y_result,
  output logic [ST_W-1:0]         status
);

  pwl_cmd_t  cmd;
  pwl_stat_t stat;

  pwl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pwl_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (mode),
    .x_value   (x_value),
    .y_value   (y_value),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .y_result  (y_result),
    .status    (status)
  );

endmodule

### rtl/core/pwl_dp.sv
module pwl_dp import pwl_pkg::*; #(
  parameter int MAX_POINTS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  pwl_cmd_t                cmd,
  output pwl_stat_t               stat,
  input  logic                    mode,
  input  logic signed [X_W-1:0]   x_value,
  input  logic signed [Y_W-1:0]   y_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] y_result,
  output logic [ST_W-1:0]         status
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = X_W + Y_W;

  // Item registers
  logic                  q_mode;
  logic signed [X_W-1:0] q_x;
  logic signed [Y_W-1:0] q_y;

  // Point table
  logic [PW-1:0] mem [MAX_POINTS];
  logic [CW-1:0] count;
  logic [CW-1:0] addr;
  logic          rd_vld;
  logic [PW-1:0] rd_data;

  // Scan results
  logic                  matched;
  logic signed [Y_W-1:0] match_y;
  logic signed [X_W-1:0] fx, cx;
  logic signed [Y_W-1:0] fy, cy;

  // Product and divisor
  logic signed [NUM_W-1:0]  num;
  logic signed [DIFF_W-1:0] den;

  // Divider
  logic [DVS_W-1:0]  rem;
  logic [NUM_W-1:0]  dd;
  logic [DVS_W-1:0]  dvs;
  logic              q_neg;
  logic [DCNT_W-1:0] dcnt;

  logic                     issue, full, wr_en;
  logic signed [X_W-1:0]    px;
  logic signed [Y_W-1:0]    py;
  logic signed [DIFF_W-1:0] dy, dx;
  logic signed [NUM_W-1:0]  prod;
  logic [NUM_W-1:0]         num_mag;
  logic [DIFF_W-1:0]        den_abs;
  logic [DVS_W:0]           rem_sh, rem_sub;
  logic                     take;
  logic signed [RES_W-1:0]  q_ext, q_val, interp;

  assign issue = cmd.scan && (addr != count);
  assign full  = (count == CW'(MAX_POINTS));
  assign wr_en = cmd.finish && (q_mode == MODE_APPEND) && !full;
  assign px    = $signed(rd_data[PW-1 -: X_W]);
  assign py    = $signed(rd_data[Y_W-1:0]);

  // Bracket differences and product
  assign dy   = DIFF_W'(cy) - DIFF_W'(fy);
  assign dx   = DIFF_W'(q_x) - DIFF_W'(fx);
  assign prod = dy * dx;

  // Magnitudes for the unsigned divider
  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_abs = den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);

  // One restoring step
  assign rem_sh  = {rem, dd[NUM_W-1]};
  assign take    = rem_sh >= {1'b0, dvs};
  assign rem_sub = rem_sh - {1'b0, dvs};

  // Signed quotient plus floor y
  assign q_ext  = $signed(RES_W'(dd));
  assign q_val  = q_neg ? -q_ext : q_ext;
  assign interp = q_val + RES_W'(fy);

  // Status to controller
  assign stat.is_query  = (q_mode == MODE_QUERY);
  assign stat.scan_done = (addr == count) && !rd_vld;
  assign stat.matched   = matched;
  assign stat.den_zero  = (den == '0);
  assign stat.div_done  = (dcnt == '0);
  assign stat.out_free  = !out_valid || out_ready;

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_mode <= mode;
      q_x    <= x_value;
      q_y    <= y_value;
    end
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]] <= {q_x, q_y};
    end
    if (issue) begin
      rd_data <= mem[addr[IW-1:0]];
    end
  end

  // Fill count, scan address and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      addr   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.load) begin
        addr <= '0;
      end else if (issue) begin
        addr <= addr + CW'(1);
      end
      if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  // Match and bracket tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      matched <= 1'b0;
      match_y <= '0;
      fx      <= FLOOR_X_START;
      fy      <= '0;
      cx      <= CEIL_X_START;
      cy      <= '0;
    end else if (rd_vld) begin
      if (px == q_x) begin
        matched <= 1'b1;
        match_y <= py;
      end
      if (q_x > px && px > fx) begin
        fx <= px;
        fy <= py;
      end
      if (q_x < px && px < cx) begin
        cx <= px;
        cy <= py;
      end
    end
  end

  // Product and divisor registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num <= prod;
      den <= DIFF_W'(cx) - DIFF_W'(fx);
    end
  end

  // Serial divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_init) begin
      dcnt <= DCNT_W'(NUM_W);
    end else if (cmd.div_step && dcnt != '0) begin
      dcnt <= dcnt - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem   <= '0;
      dd    <= num_mag;
      dvs   <= den_abs[DVS_W-1:0];
      q_neg <= num[NUM_W-1] ^ den[DIFF_W-1];
    end else if (cmd.div_step && dcnt != '0) begin
      rem <= take ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      dd  <= {dd[NUM_W-2:0], take};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (q_mode == MODE_APPEND) begin
        y_result <= '0;
        status   <= full ? ST_FULL : ST_APPENDED;
      end else if (matched) begin
        y_result <= RES_W'(match_y);
        status   <= ST_EXACT;
      end else if (den == '0) begin
        y_result <= '0;
        status   <= ST_DIVZERO;
      end else begin
        y_result <= interp;
        status   <= ST_INTERP;
      end
    end
  end

endmodule

### rtl/core/pwl_ctrl.sv
module pwl_ctrl import pwl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pwl_stat_t stat,
  output pwl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.is_query) begin
          state_next = S_FIN;
        end else begin
          cmd.scan = 1'b1;
          if (stat.scan_done) begin
            state_next = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.matched || stat.den_zero) begin
          state_next = S_FIN;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/pwl_chk.sv
module pwl_chk import pwl_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [RES_W-1:0] y_result,
  input logic [ST_W-1:0]         status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(y_result) && $stable(status))
    else $error("result changed while stalled");

  // One item in flight: accept closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after accept");

  // Only defined status codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_DIVZERO)
    else $error("undefined status code");

  // Results without a value carry zero
  a_zero_y: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_APPENDED || status == ST_FULL || status == ST_DIVZERO)
      |-> y_result == '0)
    else $error("nonzero y on append or error");

  // A match returns a stored 16-bit y
  a_exact_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EXACT
      |-> (y_result[RES_W-1:Y_W-1] == '0 || y_result[RES_W-1:Y_W-1] == '1))
    else $error("exact match y out of range");

endmodule

bind piecewise_linear_table_interp pwl_chk u_pwl_chk (.*);
